// ----- hdl/skn_pkg.sv -----
package skn_pkg;

  localparam int MaxJoints    = 256;
  localparam int JntAw        = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;
  localparam int BW           = 40;
  localparam int AW           = 17;
  localparam int PW           = AW + BW;
  localparam int RW           = PW + 1;
  localparam int TW           = 36;
  localparam int AccW         = 48;
  localparam int StepsPerVec  = 18;
  localparam int StepW        = 5;
  localparam int CntW         = 6;
  localparam int LastStep     = 2 * StepsPerVec - 1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         joint_index;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic [15:0]        bias;
    logic               last_weight;
  } skn_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } skn_rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_e;
  typedef enum logic [2:0] {A_QW, A_QX, A_QY, A_QZ, A_BIAS} asel_e;
  typedef enum logic [1:0] {B_V, B_T, B_U} bsrc_e;
  typedef enum logic [2:0] {ACT_NONE, ACT_T, ACT_H, ACT_U, ACT_ACC} act_e;

  typedef struct packed {
    asel_e      a_sel;
    bsrc_e      b_src;
    logic [1:0] b_idx;
    logic       sub;
    act_e       act;
    logic [1:0] dst;
  } uop_t;

  typedef struct packed {
    logic valid;
    logic vec;
    uop_t uop;
  } issue_t;

  function automatic uop_t uop_decode(logic [StepW-1:0] s);
    uop_t u;
    u = '{A_QW, B_V, 2'd0, 1'b0, ACT_NONE, 2'd0};
    unique case (s)
      5'd0:  u = '{A_QY, B_V, 2'd2, 1'b0, ACT_NONE, 2'd0};
      5'd1:  u = '{A_QZ, B_V, 2'd1, 1'b1, ACT_T,    2'd0};
      5'd2:  u = '{A_QZ, B_V, 2'd0, 1'b0, ACT_NONE, 2'd1};
      5'd3:  u = '{A_QX, B_V, 2'd2, 1'b1, ACT_T,    2'd1};
      5'd4:  u = '{A_QX, B_V, 2'd1, 1'b0, ACT_NONE, 2'd2};
      5'd5:  u = '{A_QY, B_V, 2'd0, 1'b1, ACT_T,    2'd2};
      5'd6:  u = '{A_QW, B_T, 2'd0, 1'b0, ACT_H,    2'd0};
      5'd7:  u = '{A_QY, B_T, 2'd2, 1'b0, ACT_NONE, 2'd0};
      5'd8:  u = '{A_QZ, B_T, 2'd1, 1'b1, ACT_U,    2'd0};
      5'd9:  u = '{A_QW, B_T, 2'd1, 1'b0, ACT_H,    2'd1};
      5'd10: u = '{A_QZ, B_T, 2'd0, 1'b0, ACT_NONE, 2'd1};
      5'd11: u = '{A_QX, B_T, 2'd2, 1'b1, ACT_U,    2'd1};
      5'd12: u = '{A_QW, B_T, 2'd2, 1'b0, ACT_H,    2'd2};
      5'd13: u = '{A_QX, B_T, 2'd1, 1'b0, ACT_NONE, 2'd2};
      5'd14: u = '{A_QY, B_T, 2'd0, 1'b1, ACT_U,    2'd2};
      5'd15: u = '{A_BIAS, B_U, 2'd0, 1'b0, ACT_ACC, 2'd0};
      5'd16: u = '{A_BIAS, B_U, 2'd1, 1'b0, ACT_ACC, 2'd1};
      5'd17: u = '{A_BIAS, B_U, 2'd2, 1'b0, ACT_ACC, 2'd2};
      default: u = '{A_QW, B_V, 2'd0, 1'b0, ACT_NONE, 2'd0};
    endcase
    return u;
  endfunction

  function automatic logic signed [RW-1:0] rnd(logic signed [RW-1:0] p, int s);
    logic signed [RW-1:0] half;
    half = RW'(1) <<< (s - 1);
    return (p + half) >>> s;
  endfunction

endpackage

// ----- hdl/weighted_joint_vertex_skinning_top.sv -----
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   in_req_i  (skn_req_t)
// out      out_valid_o/out_ready_i out_rsp_o (skn_rsp_t)
//
// A pose load writes the pose memories. A weight runs 36 steps of one shared
// 17x40 multiplier (two quaternion rotations and two blends of three components),
// then a drain state to empty the product register; a last weight then passes an emit
// state that loads the output register and waits while an earlier result is unread.
// Reset clears the accumulators and control; the pose memories are not cleared.
module weighted_joint_vertex_skinning_top import skn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  skn_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output skn_rsp_t out_rsp_o
);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ok_q, last_q;
  logic                out_valid_q, out_valid_d;
  skn_rsp_t            out_q;
  skn_rsp_t            res;
  logic                acc_in, load_acc, wgt_acc, jnt_ok, emit_go;
  logic [JntAw-1:0]    jaddr;
  logic [63:0]         rot, loc_xy;
  logic [31:0]         loc_z;
  issue_t              issue;
  logic                vec;
  logic [StepW-1:0]    step;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;
  assign jnt_ok     = int'(in_req_i.joint_index) < MaxJoints;
  assign load_acc   = acc_in && !in_req_i.kind;
  assign wgt_acc    = acc_in && in_req_i.kind;
  assign jaddr      = JntAw'(in_req_i.joint_index);
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  skn_ram #(.Width(64), .Depth(MaxJoints)) u_rot (
    .clk_i, .we_i(load_acc && jnt_ok), .waddr_i(jaddr),
    .wdata_i({in_req_i.b_z, in_req_i.b_y, in_req_i.b_x, in_req_i.b_w}),
    .re_i(wgt_acc), .raddr_i(jaddr), .rdata_o(rot)
  );

  skn_ram #(.Width(64), .Depth(MaxJoints)) u_loc_xy (
    .clk_i, .we_i(load_acc && jnt_ok), .waddr_i(jaddr),
    .wdata_i({in_req_i.a_y, in_req_i.a_x}),
    .re_i(wgt_acc), .raddr_i(jaddr), .rdata_o(loc_xy)
  );

  skn_ram #(.Width(32), .Depth(MaxJoints)) u_loc_z (
    .clk_i, .we_i(load_acc && jnt_ok), .waddr_i(jaddr),
    .wdata_i(in_req_i.a_z),
    .re_i(wgt_acc), .raddr_i(jaddr), .rdata_o(loc_z)
  );

  assign vec         = cnt_q >= CntW'(StepsPerVec);
  assign step        = vec ? StepW'(cnt_q - CntW'(StepsPerVec)) : StepW'(cnt_q);
  assign issue.valid = (state_q == ST_RUN);
  assign issue.vec   = vec;
  assign issue.uop   = uop_decode(step);

  skn_dp u_dp (
    .clk_i, .rst_ni, .load_i(wgt_acc), .req_i(in_req_i),
    .rot_i(rot), .loc_xy_i(loc_xy), .loc_z_i(loc_z), .jnt_ok_i(ok_q),
    .issue_i(issue), .clr_i(emit_go), .res_o(res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (wgt_acc) state_d = ST_RUN;
      ST_RUN:   if (cnt_q == CntW'(LastStep)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (emit_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE:  cnt_d = '0;
      ST_RUN:   cnt_d = cnt_q + CntW'(1);
      ST_DRAIN: cnt_d = '0;
      ST_EMIT:  if (emit_go) out_valid_d = 1'b1;
      default:  cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (wgt_acc) begin
        ok_q   <= jnt_ok;
        last_q <= in_req_i.last_weight;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT)) else $error("result without emit");
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q != CntW'(LastStep)) |=> (state_q == ST_RUN &&
    cnt_q == $past(cnt_q) + CntW'(1))) else $error("step counter slipped");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> !in_ready_o) else $error("ready while stepping");
`endif

endmodule

// ----- hdl/skn_ram.sv -----
module skn_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/skn_dp.sv -----
module skn_dp import skn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  skn_req_t    req_i,
  input  logic [63:0] rot_i,
  input  logic [63:0] loc_xy_i,
  input  logic [31:0] loc_z_i,
  input  logic        jnt_ok_i,
  input  issue_t      issue_i,
  input  logic        clr_i,
  output skn_rsp_t    res_o
);

  skn_req_t                req_q;
  issue_t                  ctl_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [RW-1:0]    p_q;
  logic signed [TW-1:0]    t_q    [3];
  logic signed [BW-1:0]    h_q    [3];
  logic signed [BW-1:0]    u_q    [3];
  logic signed [AccW-1:0]  pacc_q [3];
  logic signed [AccW-1:0]  nacc_q [3];

  logic signed [15:0]      q      [4];
  logic signed [BW-1:0]    vp     [3];
  logic signed [BW-1:0]    vn     [3];
  logic signed [BW-1:0]    loc    [3];
  logic signed [AW-1:0]    a_op;
  logic signed [BW-1:0]    b_op;
  logic signed [BW-1:0]    v_iss;
  logic signed [BW-1:0]    v_cmp;
  logic signed [PW-1:0]    prod_d;
  logic signed [RW-1:0]    p_cur;
  logic signed [RW-1:0]    r13;
  logic signed [RW-1:0]    r14;
  logic signed [RW-1:0]    r15;
  logic signed [BW-1:0]    loc_sel;
  logic signed [AccW:0]    sum;
  logic signed [AccW-1:0]  sum_sat;

  assign q[0] = jnt_ok_i ? rot_i[15:0]  : 16'sd0;
  assign q[1] = jnt_ok_i ? rot_i[31:16] : 16'sd0;
  assign q[2] = jnt_ok_i ? rot_i[47:32] : 16'sd0;
  assign q[3] = jnt_ok_i ? rot_i[63:48] : 16'sd0;

  assign loc[0] = jnt_ok_i ? BW'($signed(loc_xy_i[31:0]))  : '0;
  assign loc[1] = jnt_ok_i ? BW'($signed(loc_xy_i[63:32])) : '0;
  assign loc[2] = jnt_ok_i ? BW'($signed(loc_z_i))         : '0;

  assign vp[0] = BW'(req_q.a_x);
  assign vp[1] = BW'(req_q.a_y);
  assign vp[2] = BW'(req_q.a_z);
  assign vn[0] = BW'(req_q.b_x);
  assign vn[1] = BW'(req_q.b_y);
  assign vn[2] = BW'(req_q.b_z);

  always_comb begin
    case (issue_i.uop.a_sel)
      A_QW:    a_op = AW'(q[0]);
      A_QX:    a_op = AW'(q[1]);
      A_QY:    a_op = AW'(q[2]);
      A_QZ:    a_op = AW'(q[3]);
      A_BIAS:  a_op = $signed({1'b0, req_q.bias});
      default: a_op = '0;
    endcase
    v_iss = issue_i.vec ? vn[issue_i.uop.b_idx] : vp[issue_i.uop.b_idx];
    case (issue_i.uop.b_src)
      B_V:     b_op = v_iss;
      B_T:     b_op = BW'(t_q[issue_i.uop.b_idx]);
      B_U:     b_op = u_q[issue_i.uop.b_idx];
      default: b_op = '0;
    endcase
  end

  assign prod_d = PW'(a_op * b_op);

  assign p_cur   = ctl_q.uop.sub ? (p_q - RW'(prod_q)) : RW'(prod_q);
  assign r13     = rnd(p_cur, 13);
  assign r14     = rnd(p_cur, 14);
  assign r15     = rnd(p_cur, 15);
  assign v_cmp   = ctl_q.vec ? vn[ctl_q.uop.dst] : vp[ctl_q.uop.dst];
  assign loc_sel = ctl_q.vec ? '0 : loc[ctl_q.uop.dst];
  assign sum     = ctl_q.vec ? ((AccW+1)'(nacc_q[ctl_q.uop.dst]) + (AccW+1)'(r15))
                             : ((AccW+1)'(pacc_q[ctl_q.uop.dst]) + (AccW+1)'(r15));

  always_comb begin
    if (sum > $signed({2'b00, {(AccW-1){1'b1}}})) begin
      sum_sat = {1'b0, {(AccW-1){1'b1}}};
    end else if (sum < $signed({2'b11, {(AccW-1){1'b0}}})) begin
      sum_sat = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      sum_sat = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      req_q <= req_i;
    end
    prod_q <= prod_d;
    if (ctl_q.valid) begin
      p_q <= p_cur;
      case (ctl_q.uop.act)
        ACT_T:   t_q[ctl_q.uop.dst] <= r13[TW-1:0];
        ACT_H:   h_q[ctl_q.uop.dst] <= v_cmp + r14[BW-1:0];
        ACT_U:   u_q[ctl_q.uop.dst] <= h_q[ctl_q.uop.dst] + r14[BW-1:0] + loc_sel;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pacc_q[i] <= '0;
        nacc_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < 3; i++) begin
        pacc_q[i] <= '0;
        nacc_q[i] <= '0;
      end
    end else if (ctl_q.valid && ctl_q.uop.act == ACT_ACC) begin
      if (ctl_q.vec) begin
        nacc_q[ctl_q.uop.dst] <= sum_sat;
      end else begin
        pacc_q[ctl_q.uop.dst] <= sum_sat;
      end
    end
  end

  function automatic logic signed [31:0] sat32(logic signed [AccW-1:0] v);
    if (v > AccW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < AccW'(-32'sh7fffffff - 32'sd1)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [AccW-1:0] v);
    if (v > AccW'(16'sh7fff)) return 16'sh7fff;
    if (v < AccW'(-16'sh7fff - 16'sd1)) return 16'sh8000;
    return v[15:0];
  endfunction

  assign res_o.pos_x    = sat32(pacc_q[0]);
  assign res_o.pos_y    = sat32(pacc_q[1]);
  assign res_o.pos_z    = sat32(pacc_q[2]);
  assign res_o.normal_x = sat16(nacc_q[0]);
  assign res_o.normal_y = sat16(nacc_q[1]);
  assign res_o.normal_z = sat16(nacc_q[2]);

endmodule
